[src/gmds_pkg.sv]
package gmds_pkg;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STEP  = 2'd2;

	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_RIGHT = 2'd1;
	localparam logic [1:0] DIR_DOWN  = 2'd2;
	localparam logic [1:0] DIR_LEFT  = 2'd3;

	localparam logic [2:0] START_TRIES = 3'd4;
	localparam logic [2:0] CHILD_TRIES = 3'd3;

	localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_GOAL_X      = 2'd2;
	localparam logic [1:0] CFG_GOAL_Y      = 2'd3;

	localparam int CFG_DATA_W = 7;
	localparam int COORD_W    = 6;
	localparam int DIM_W      = 7;
	localparam int DIM_CAP    = 64;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [COORD_W-1:0] cell_x;
		logic [COORD_W-1:0] cell_y;
		logic               cell_open;
	} cmd_t;

	typedef struct packed {
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
		logic               reached_goal;
		logic               search_failed;
	} result_t;

	typedef struct packed {
		logic [DIM_W-1:0]   grid_width;
		logic [DIM_W-1:0]   grid_height;
		logic [COORD_W-1:0] goal_x;
		logic [COORD_W-1:0] goal_y;
	} cfg_t;

	typedef struct packed {
		logic [2:0]         tries;
		logic [1:0]         dir;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
	} stk_entry_t;

endpackage

[src/gmds_engine.sv]
module gmds_engine #(
	parameter int MAX_WIDTH   = 64,
	parameter int MAX_HEIGHT  = 64,
	parameter int STACK_DEPTH = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  gmds_pkg::cmd_t   cmd,
	input  gmds_pkg::cfg_t   cfg,
	output logic             busy,
	output logic             emit,
	output gmds_pkg::result_t res
);

	localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(CELLS);
	localparam int SW    = $clog2(STACK_DEPTH);
	localparam int CW    = $clog2(STACK_DEPTH + 1);
	localparam int CRD   = gmds_pkg::COORD_W;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_WR   = 4'd1;
	localparam logic [3:0] ST_SW   = 4'd2;
	localparam logic [3:0] ST_TOP  = 4'd3;
	localparam logic [3:0] ST_POP  = 4'd4;
	localparam logic [3:0] ST_NB   = 4'd5;
	localparam logic [3:0] ST_CHK  = 4'd6;
	localparam logic [3:0] ST_EMIT = 4'd7;

	typedef struct packed {
		logic          open;
		logic [SW-1:0] idx;
	} map_word_t;

	map_word_t            map_mem [CELLS];
	gmds_pkg::stk_entry_t stk_mem [STACK_DEPTH];

	logic [3:0]           state_q, state_d;
	logic [CW-1:0]        count_q, count_d;
	logic [CRD-1:0]       cur_x_q, cur_x_d, cur_y_q, cur_y_d;
	logic [CRD-1:0]       nb_x_q, nb_x_d, nb_y_q, nb_y_d;
	logic [1:0]           nb_dir_q, nb_dir_d;
	logic [AW-1:0]        addr_q, addr_d;
	logic                 open_q;

	logic                 map_re, map_we;
	logic [AW-1:0]        map_raddr, map_waddr;
	map_word_t            map_wdata, map_rd;
	logic                 stk_re, stk_we;
	logic [SW-1:0]        stk_raddr, stk_waddr;
	gmds_pkg::stk_entry_t stk_wdata, stk_rd;

	logic [gmds_pkg::DIM_W-1:0] lim_w, lim_h;
	logic                 cmd_in_store, reached, nb_ok;
	logic [AW-1:0]        cmd_addr, nb_addr;
	logic [CRD-1:0]       nx, ny;

	always_comb begin
		lim_w = cfg.grid_width;
		if (lim_w < 7'd3) lim_w = 7'd3;
		if (int'(lim_w) > MAX_WIDTH) lim_w = gmds_pkg::DIM_W'(MAX_WIDTH);
		if (int'(lim_w) > gmds_pkg::DIM_CAP) lim_w = gmds_pkg::DIM_W'(gmds_pkg::DIM_CAP);
		lim_h = cfg.grid_height;
		if (lim_h < 7'd3) lim_h = 7'd3;
		if (int'(lim_h) > MAX_HEIGHT) lim_h = gmds_pkg::DIM_W'(MAX_HEIGHT);
		if (int'(lim_h) > gmds_pkg::DIM_CAP) lim_h = gmds_pkg::DIM_W'(gmds_pkg::DIM_CAP);
	end

	assign cmd_in_store = (int'(cmd.cell_x) < MAX_WIDTH) && (int'(cmd.cell_y) < MAX_HEIGHT);
	assign cmd_addr     = AW'(int'(cmd.cell_y) * MAX_WIDTH + int'(cmd.cell_x));
	assign reached      = (cur_x_q == cfg.goal_x) && (cur_y_q == cfg.goal_y);

	always_comb begin
		nx    = stk_rd.x;
		ny    = stk_rd.y;
		nb_ok = 1'b0;
		case (stk_rd.dir)
			gmds_pkg::DIR_UP: begin
				ny    = stk_rd.y - 1'b1;
				nb_ok = stk_rd.y != '0;
			end
			gmds_pkg::DIR_RIGHT: begin
				nx    = stk_rd.x + 1'b1;
				nb_ok = ({1'b0, stk_rd.x} + 7'd1) < lim_w;
			end
			gmds_pkg::DIR_DOWN: begin
				ny    = stk_rd.y + 1'b1;
				nb_ok = ({1'b0, stk_rd.y} + 7'd1) < lim_h;
			end
			gmds_pkg::DIR_LEFT: begin
				nx    = stk_rd.x - 1'b1;
				nb_ok = stk_rd.x != '0;
			end
			default: begin
				nb_ok = 1'b0;
			end
		endcase
		nb_ok = nb_ok && ({1'b0, nx} < lim_w) && ({1'b0, ny} < lim_h);
	end

	assign nb_addr = AW'(int'(ny) * MAX_WIDTH + int'(nx));

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		cur_x_d   = cur_x_q;
		cur_y_d   = cur_y_q;
		nb_x_d    = nb_x_q;
		nb_y_d    = nb_y_q;
		nb_dir_d  = nb_dir_q;
		addr_d    = addr_q;
		map_re    = 1'b0;
		map_raddr = cmd_addr;
		map_we    = 1'b0;
		map_waddr = addr_q;
		map_wdata = map_rd;
		stk_re    = 1'b0;
		stk_raddr = SW'(count_q - 1'b1);
		stk_we    = 1'b0;
		stk_waddr = SW'(count_q - 1'b1);
		stk_wdata = stk_rd;
		case (state_q)
			ST_IDLE: begin
				if (go) begin
					addr_d = cmd_addr;
					case (cmd.opcode)
						gmds_pkg::OP_WRITE: begin
							if (cmd_in_store) begin
								map_re  = 1'b1;
								state_d = ST_WR;
							end
						end
						gmds_pkg::OP_START: begin
							stk_we    = 1'b1;
							stk_waddr = '0;
							stk_wdata = '{tries: gmds_pkg::START_TRIES, dir: gmds_pkg::DIR_UP,
								y: cmd.cell_y, x: cmd.cell_x};
							count_d   = CW'(1);
							cur_x_d   = cmd.cell_x;
							cur_y_d   = cmd.cell_y;
							if (cmd_in_store) begin
								map_re  = 1'b1;
								state_d = ST_SW;
							end else begin
								state_d = ST_EMIT;
							end
						end
						gmds_pkg::OP_STEP: begin
							if (reached || count_q == '0) begin
								state_d = ST_EMIT;
							end else begin
								stk_re  = 1'b1;
								state_d = ST_TOP;
							end
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_WR: begin
				map_we    = 1'b1;
				map_wdata = '{open: open_q, idx: map_rd.idx};
				state_d   = ST_IDLE;
			end
			ST_SW: begin
				map_we    = 1'b1;
				map_wdata = '{open: map_rd.open, idx: '0};
				state_d   = ST_EMIT;
			end
			ST_TOP: begin
				if (stk_rd.tries == '0) begin
					count_d = count_q - 1'b1;
					if (count_q > CW'(1)) begin
						stk_re    = 1'b1;
						stk_raddr = SW'(count_q - CW'(2));
						state_d   = ST_POP;
					end else begin
						cur_x_d = stk_rd.x;
						cur_y_d = stk_rd.y;
						state_d = ST_EMIT;
					end
				end else begin
					stk_we    = 1'b1;
					stk_wdata = '{tries: stk_rd.tries - 1'b1, dir: stk_rd.dir + 1'b1,
						y: stk_rd.y, x: stk_rd.x};
					cur_x_d   = stk_rd.x;
					cur_y_d   = stk_rd.y;
					nb_x_d    = nx;
					nb_y_d    = ny;
					nb_dir_d  = stk_rd.dir + 2'd3;
					addr_d    = nb_addr;
					if (nb_ok) begin
						map_re    = 1'b1;
						map_raddr = nb_addr;
						state_d   = ST_NB;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_POP: begin
				cur_x_d = stk_rd.x;
				cur_y_d = stk_rd.y;
				state_d = ST_EMIT;
			end
			ST_NB, ST_CHK: begin
				state_d = ST_EMIT;
				if (state_q == ST_NB && !map_rd.open) begin
					state_d = ST_EMIT;
				end else if (state_q == ST_NB && ({1'b0, map_rd.idx} < CW'(count_q))) begin
					stk_re    = 1'b1;
					stk_raddr = map_rd.idx;
					state_d   = ST_CHK;
				end else if (state_q == ST_CHK && stk_rd.x == nb_x_q && stk_rd.y == nb_y_q) begin
					state_d = ST_EMIT;
				end else if (int'(count_q) < STACK_DEPTH) begin
					stk_we    = 1'b1;
					stk_waddr = SW'(count_q);
					stk_wdata = '{tries: gmds_pkg::CHILD_TRIES, dir: nb_dir_q,
						y: nb_y_q, x: nb_x_q};
					map_we    = 1'b1;
					map_waddr = addr_q;
					map_wdata = '{open: 1'b1, idx: SW'(count_q)};
					count_d   = count_q + 1'b1;
					cur_x_d   = nb_x_q;
					cur_y_d   = nb_y_q;
				end
			end
			ST_EMIT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (map_we) map_mem[map_waddr] <= map_wdata;
		if (map_re) map_rd <= map_mem[map_raddr];
	end

	always_ff @(posedge clk) begin
		if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
		if (stk_re) stk_rd <= stk_mem[stk_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			cur_x_q <= '0;
			cur_y_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			cur_x_q <= cur_x_d;
			cur_y_q <= cur_y_d;
		end
	end

	always_ff @(posedge clk) begin
		nb_x_q   <= nb_x_d;
		nb_y_q   <= nb_y_d;
		nb_dir_q <= nb_dir_d;
		addr_q   <= addr_d;
		if (go) open_q <= cmd.cell_open;
	end

	assign busy = state_q != ST_IDLE;
	assign emit = state_q == ST_EMIT;

	always_comb begin
		res.pos_x         = cur_x_q;
		res.pos_y         = cur_y_q;
		res.reached_goal  = reached;
		res.search_failed = (count_q == '0) && !reached;
	end

endmodule

[src/grid_maze_dfs_solver.sv]
// Grid maze depth-first search solver. Load the map with write transactions, then send a
// start transaction and one step transaction per move; each start or step produces exactly
// one result on result, marked by result_valid for a single cycle, and the receiver cannot
// stall it. A transaction is taken when start is high and busy is low. A cell write keeps
// busy high for a read-modify-write of the map memory (none when the cell lies outside the
// map store). Each step that is not yet at the goal or out of stack entries chains
// registered reads of the stack memory (top entry, parent entry or the on-stack index
// check) and of the map memory (neighbor cell), then a write-back.
// The on-stack check holds a stack index per cell and confirms it against the stack, so no
// clearing pass is needed after reset or at start. Write configuration only while idle.
module grid_maze_dfs_solver #(
	parameter int MAX_WIDTH   = 64,
	parameter int MAX_HEIGHT  = 64,
	parameter int STACK_DEPTH = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  gmds_pkg::cmd_t                      cmd,
	output logic                                result_valid,
	output gmds_pkg::result_t                   result,
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [gmds_pkg::CFG_DATA_W-1:0]     cfg_data
);

	gmds_pkg::cfg_t    cfg_q;
	gmds_pkg::result_t res;
	gmds_pkg::result_t result_q;
	logic              result_valid_q;
	logic              go, emit;

	assign go = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_width  <= gmds_pkg::DIM_W'(64);
			cfg_q.grid_height <= gmds_pkg::DIM_W'(64);
			cfg_q.goal_x      <= '0;
			cfg_q.goal_y      <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				gmds_pkg::CFG_GRID_WIDTH:  cfg_q.grid_width  <= cfg_data;
				gmds_pkg::CFG_GRID_HEIGHT: cfg_q.grid_height <= cfg_data;
				gmds_pkg::CFG_GOAL_X:      cfg_q.goal_x      <= cfg_data[gmds_pkg::COORD_W-1:0];
				gmds_pkg::CFG_GOAL_Y:      cfg_q.goal_y      <= cfg_data[gmds_pkg::COORD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	gmds_engine #(
		.MAX_WIDTH   (MAX_WIDTH),
		.MAX_HEIGHT  (MAX_HEIGHT),
		.STACK_DEPTH (STACK_DEPTH)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.cmd    (cmd),
		.cfg    (cfg_q),
		.busy   (busy),
		.emit   (emit),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) result_q <= res;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_result_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("results in consecutive cycles");

	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result without a transaction in progress");

	a_result_flags: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.reached_goal && result.search_failed))
		else $error("goal reached and search failed together");

endmodule

[tb/sv/tb.sv]
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int MAP_CELLS      = gmds_pkg::DIM_CAP * gmds_pkg::DIM_CAP;
	localparam int STACK_SLOTS    = 4096;
	localparam int ITEM_TARGET    = 550;
	localparam int CALM_FROM      = 480;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS    = 50;
	localparam int CRD_W          = gmds_pkg::COORD_W;
	localparam int DIM_W          = gmds_pkg::DIM_W;
	localparam int CFG_W          = gmds_pkg::CFG_DATA_W;

	class dfs_tracker;
		bit                   cell_open_map [MAP_CELLS];
		bit                   cell_known [MAP_CELLS];
		bit                   on_stack [MAP_CELLS];
		gmds_pkg::stk_entry_t dfs_stack [STACK_SLOTS];
		int                   depth;
		logic [CRD_W-1:0]     pos_x, pos_y;
		logic [DIM_W-1:0]     width_reg, height_reg;
		logic [CRD_W-1:0]     goal_x, goal_y;
		gmds_pkg::result_t    expected_positions [$];
		int                   errors;

		function new();
			depth      = 0;
			pos_x      = '0;
			pos_y      = '0;
			width_reg  = 7'd64;
			height_reg = 7'd64;
			goal_x     = '0;
			goal_y     = '0;
			errors     = 0;
		endfunction

		function int limit_dim(logic [DIM_W-1:0] v);
			int r;
			r = v;
			if (r < 3)
				r = 3;
			if (r > gmds_pkg::DIM_CAP)
				r = gmds_pkg::DIM_CAP;
			return r;
		endfunction

		function int cell_index(int x, int y);
			return y * gmds_pkg::DIM_CAP + x;
		endfunction

		function bit in_grid(int x, int y);
			return x >= 0 && y >= 0 && x < limit_dim(width_reg) && y < limit_dim(height_reg);
		endfunction

		function bit at_goal();
			return pos_x == goal_x && pos_y == goal_y;
		endfunction

		function bit search_done();
			return at_goal() || depth == 0;
		endfunction

		function void neighbor_of(gmds_pkg::stk_entry_t e, output int nx, output int ny);
			nx = e.x;
			ny = e.y;
			case (e.dir)
				gmds_pkg::DIR_UP:    ny = ny - 1;
				gmds_pkg::DIR_RIGHT: nx = nx + 1;
				gmds_pkg::DIR_DOWN:  ny = ny + 1;
				gmds_pkg::DIR_LEFT:  nx = nx - 1;
				default: begin
				end
			endcase
		endfunction

		function bit unknown_neighbor(output int nx, output int ny);
			gmds_pkg::stk_entry_t top;
			nx = 0;
			ny = 0;
			if (search_done())
				return 1'b0;
			top = dfs_stack[depth-1];
			if (top.tries == 0)
				return 1'b0;
			neighbor_of(top, nx, ny);
			return in_grid(nx, ny) && !cell_known[cell_index(nx, ny)];
		endfunction

		function void set_register(logic [1:0] index, logic [CFG_W-1:0] data);
			case (index)
				gmds_pkg::CFG_GRID_WIDTH:  width_reg = data;
				gmds_pkg::CFG_GRID_HEIGHT: height_reg = data;
				gmds_pkg::CFG_GOAL_X:      goal_x = data[CRD_W-1:0];
				gmds_pkg::CFG_GOAL_Y:      goal_y = data[CRD_W-1:0];
				default: begin
				end
			endcase
		endfunction

		function void advance();
			gmds_pkg::stk_entry_t top;
			int nx, ny;
			logic [1:0] child_dir;
			if (search_done())
				return;
			top = dfs_stack[depth-1];
			if (top.tries == 0) begin
				on_stack[cell_index(top.x, top.y)] = 1'b0;
				depth--;
				if (depth > 0) begin
					pos_x = dfs_stack[depth-1].x;
					pos_y = dfs_stack[depth-1].y;
				end else begin
					pos_x = top.x;
					pos_y = top.y;
				end
				return;
			end
			dfs_stack[depth-1].dir   = top.dir + 2'd1;
			dfs_stack[depth-1].tries = top.tries - 3'd1;
			pos_x = top.x;
			pos_y = top.y;
			neighbor_of(top, nx, ny);
			if (!in_grid(nx, ny) || !cell_open_map[cell_index(nx, ny)])
				return;
			if (on_stack[cell_index(nx, ny)] || depth >= STACK_SLOTS)
				return;
			child_dir = top.dir + 2'd3;
			dfs_stack[depth] = '{tries: gmds_pkg::CHILD_TRIES, dir: child_dir,
				y: ny[CRD_W-1:0], x: nx[CRD_W-1:0]};
			depth++;
			on_stack[cell_index(nx, ny)] = 1'b1;
			pos_x = nx[CRD_W-1:0];
			pos_y = ny[CRD_W-1:0];
		endfunction

		function void note_command(gmds_pkg::cmd_t c);
			gmds_pkg::result_t r;
			case (c.opcode)
				gmds_pkg::OP_WRITE: begin
					cell_open_map[cell_index(c.cell_x, c.cell_y)] = c.cell_open;
					cell_known[cell_index(c.cell_x, c.cell_y)] = 1'b1;
					return;
				end
				gmds_pkg::OP_START: begin
					foreach (on_stack[i])
						on_stack[i] = 1'b0;
					dfs_stack[0] = '{tries: gmds_pkg::START_TRIES, dir: gmds_pkg::DIR_UP,
						y: c.cell_y, x: c.cell_x};
					depth = 1;
					on_stack[cell_index(c.cell_x, c.cell_y)] = 1'b1;
					pos_x = c.cell_x;
					pos_y = c.cell_y;
				end
				gmds_pkg::OP_STEP: advance();
				default: return;
			endcase
			r.pos_x         = pos_x;
			r.pos_y         = pos_y;
			r.reached_goal  = at_goal();
			r.search_failed = depth == 0 && !at_goal();
			expected_positions = {expected_positions, r};
		endfunction

		task report(string msg);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("ERROR: %s", msg);
		endtask

		task check_position(gmds_pkg::result_t got);
			gmds_pkg::result_t want;
			if (expected_positions.size() == 0) begin
				report("result with no pending transaction");
				return;
			end
			want = expected_positions.pop_front();
			if (got.pos_x !== want.pos_x)
				report($sformatf("pos_x got %0d expected %0d", got.pos_x, want.pos_x));
			if (got.pos_y !== want.pos_y)
				report($sformatf("pos_y got %0d expected %0d", got.pos_y, want.pos_y));
			if (got.reached_goal !== want.reached_goal)
				report($sformatf("reached_goal got %b expected %b",
					got.reached_goal, want.reached_goal));
			if (got.search_failed !== want.search_failed)
				report($sformatf("search_failed got %b expected %b",
					got.search_failed, want.search_failed));
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	gmds_pkg::cmd_t    cmd;
	logic              result_valid;
	gmds_pkg::result_t result;
	logic              cfg_we;
	logic [1:0]        cfg_index;
	logic [CFG_W-1:0]  cfg_data;

	dfs_tracker tracker;
	int         items_sent;
	bit         gaps_on;
	int         open_pct;

	grid_maze_dfs_solver uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.result_valid (result_valid),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit chance(int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic gmds_pkg::cmd_t make_cmd(logic [1:0] op, int x, int y, bit open);
		gmds_pkg::cmd_t c;
		c.opcode    = op;
		c.cell_x    = x[CRD_W-1:0];
		c.cell_y    = y[CRD_W-1:0];
		c.cell_open = open;
		return c;
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim();
		case ($urandom_range(0, 9))
			0:       return DIM_W'($urandom_range(0, 2));
			1:       return 7'd127;
			2:       return 7'd64;
			3:       return DIM_W'($urandom_range(0, 127));
			default: return DIM_W'($urandom_range(3, 6));
		endcase
	endfunction

	task send_command(gmds_pkg::cmd_t c);
		cmd   <= c;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		tracker.note_command(c);
		if (c.opcode != OP_UNUSED)
			items_sent++;
		@(negedge clk);
		if (gaps_on && items_sent < CALM_FROM && chance(25)) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
	endtask

	// hold off until every pending transaction has produced its result
	task drain();
		start <= 1'b0;
		while (tracker.expected_positions.size() != 0 || busy !== 1'b0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task configure(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
			logic [CRD_W-1:0] gx, logic [CRD_W-1:0] gy);
		logic [1:0]       regs [4];
		logic [CFG_W-1:0] vals [4];
		regs = '{gmds_pkg::CFG_GRID_WIDTH, gmds_pkg::CFG_GRID_HEIGHT,
			gmds_pkg::CFG_GOAL_X, gmds_pkg::CFG_GOAL_Y};
		vals = '{w, h, {1'b0, gx}, {1'b0, gy}};
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			@(negedge clk);
			tracker.set_register(regs[i], vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// write any unwritten cell the next step would read, then step
	task step_search();
		int rx, ry;
		while (tracker.unknown_neighbor(rx, ry))
			send_command(make_cmd(gmds_pkg::OP_WRITE, rx, ry, chance(open_pct)));
		send_command(make_cmd(gmds_pkg::OP_STEP, $urandom_range(0, 63),
			$urandom_range(0, 63), $urandom_range(0, 1)));
	endtask

	task run_phase(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
			logic [CRD_W-1:0] gx, logic [CRD_W-1:0] gy, int budget);
		int cols, rows;
		drain();
		configure(w, h, gx, gy);
		cols = tracker.limit_dim(w);
		rows = tracker.limit_dim(h);
		open_pct = $urandom_range(40, 95);
		repeat ($urandom_range(0, 6))
			send_command(make_cmd(gmds_pkg::OP_WRITE, $urandom_range(0, cols - 1),
				$urandom_range(0, rows - 1), chance(open_pct)));
		if (chance(10))
			send_command(make_cmd(gmds_pkg::OP_START, $urandom_range(0, 63),
				$urandom_range(0, 63), $urandom_range(0, 1)));
		else
			send_command(make_cmd(gmds_pkg::OP_START, $urandom_range(0, cols - 1),
				$urandom_range(0, rows - 1), $urandom_range(0, 1)));
		for (int n = 0; n < budget && !tracker.search_done() && items_sent < ITEM_TARGET;
				n++) begin
			case ($urandom_range(0, 39))
				0: send_command(make_cmd(gmds_pkg::OP_WRITE, $urandom_range(0, 63),
					$urandom_range(0, 63), chance(open_pct)));
				1: send_command(make_cmd(gmds_pkg::OP_START, $urandom_range(0, cols - 1),
					$urandom_range(0, rows - 1), $urandom_range(0, 1)));
				2: send_command(make_cmd(OP_UNUSED, $urandom_range(0, 63),
					$urandom_range(0, 63), $urandom_range(0, 1)));
				3: drain();
				default: step_search();
			endcase
		end
		repeat ($urandom_range(0, 2)) step_search();
	endtask

	always @(posedge clk) begin
		if (result_valid === 1'b1)
			tracker.check_position(result);
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || result_valid === 1'b1)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		logic [DIM_W-1:0] w, h;
		logic [CRD_W-1:0] gx, gy;
		int               cols, rows;
		tracker    = new();
		arst_n     = 1'b0;
		start      = 1'b0;
		cmd        = '0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		items_sent = 0;
		gaps_on    = 1'b0;
		open_pct   = 100;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_command(make_cmd(gmds_pkg::OP_STEP, 0, 0, 0));
		send_command(make_cmd(OP_UNUSED, 63, 63, 1));
		drain();
		configure(7'd3, 7'd3, 6'd2, 6'd2);
		send_command(make_cmd(gmds_pkg::OP_WRITE, 63, 63, 1));
		send_command(make_cmd(gmds_pkg::OP_WRITE, 0, 63, 0));
		send_command(make_cmd(gmds_pkg::OP_WRITE, 63, 0, 1));
		send_command(make_cmd(gmds_pkg::OP_WRITE, 0, 0, 1));
		send_command(make_cmd(gmds_pkg::OP_WRITE, 1, 1, 0));
		send_command(make_cmd(gmds_pkg::OP_START, 0, 0, 0));
		for (int n = 0; n < 12 && !tracker.search_done(); n++)
			step_search();
		send_command(make_cmd(gmds_pkg::OP_START, 63, 63, 1));
		repeat (6) step_search();
		send_command(make_cmd(gmds_pkg::OP_START, 2, 2, 0));
		step_search();

		gaps_on = 1'b1;
		run_phase(7'd127, 7'd0, 6'd63, 6'd0, 200);
		while (items_sent < ITEM_TARGET) begin
			w    = pick_dim();
			h    = pick_dim();
			cols = tracker.limit_dim(w);
			rows = tracker.limit_dim(h);
			if (chance(20)) begin
				gx = $urandom_range(0, 63);
				gy = $urandom_range(0, 63);
			end else begin
				gx = $urandom_range(0, cols - 1);
				gy = $urandom_range(0, rows - 1);
			end
			gaps_on = chance(75);
			run_phase(w, h, gx, gy, cols * rows > 64 ? 60 : 150);
		end
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.errors == 0 && tracker.expected_positions.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

[filelist.f]
src/gmds_pkg.sv
src/gmds_engine.sv
src/grid_maze_dfs_solver.sv
tb/sv/tb.sv
